FILE: hdl/modinv_pkg.sv
// modinv_pkg: shared types and constants for the modular inverse block
// micro-op and status types used by the sequencer and the top level datapath
// no dependencies
`timescale 1ns / 1ps

package modinv_pkg;

	localparam logic [63:0] MODULUS_RESET = 64'd1000000007;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_LOAD,
		OP_DIV_EUC,
		OP_UPDATE,
		OP_DIV_RED,
		OP_FIX,
		OP_BADMOD,
		OP_EMIT
	} op_t;

	typedef struct packed {
		logic in_valid;
		logic div_busy;
		logic out_free;
		logic r_zero;
		logic m_small;
	} sts_t;

endpackage

FILE: hdl/modinv_div.sv
// modinv_div: shared restoring divider, one quotient bit per cycle
// also accumulates quotient times a signed multiplicand, msb first
// depends on nothing
`timescale 1ns / 1ps

module modinv_div #(
	parameter int WORD_BITS = 31
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [WORD_BITS:0]          dividend,
	input  logic [WORD_BITS-1:0]        divisor,
	input  logic signed [WORD_BITS+2:0] mcand,
	output logic                        busy,
	output logic [WORD_BITS-1:0]        rem,
	output logic signed [WORD_BITS+2:0] prod
);

	localparam int DW = WORD_BITS + 1;
	localparam int SW = WORD_BITS + 3;
	localparam int CNT_BITS = $clog2(DW + 1);

	logic [WORD_BITS-1:0]   rem_q;
	logic [DW-1:0]          dvd_q;
	logic [WORD_BITS-1:0]   dsr_q;
	logic signed [SW-1:0]   mc_q;
	logic signed [SW-1:0]   prod_q;
	logic [CNT_BITS-1:0]    cnt_q;
	logic                   busy_q;

	logic [WORD_BITS:0]     rem_sh;
	logic                   ge;
	logic [WORD_BITS:0]     rem_diff;
	logic signed [SW-1:0]   prod_nx;

	assign rem_sh   = {rem_q, dvd_q[DW-1]};
	assign ge       = (rem_sh >= {1'b0, dsr_q});
	assign rem_diff = ge ? (rem_sh - {1'b0, dsr_q}) : rem_sh;
	assign prod_nx  = (prod_q <<< 1) + (ge ? mc_q : SW'(0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_BITS'(DW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_BITS'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			dvd_q  <= dividend;
			dsr_q  <= divisor;
			mc_q   <= mcand;
			prod_q <= '0;
		end else if (busy_q) begin
			rem_q  <= rem_diff[WORD_BITS-1:0];
			dvd_q  <= {dvd_q[DW-2:0], 1'b0};
			prod_q <= prod_nx;
		end
	end

	assign busy = busy_q;
	assign rem  = rem_q;
	assign prod = prod_q;

endmodule

FILE: hdl/modinv_seq.sv
// modinv_seq: step counter and microcode rom for the extended euclid program
// emits one micro-op per step, branches on datapath status
// depends on modinv_pkg
`timescale 1ns / 1ps

module modinv_seq (
	input  logic               clk,
	input  logic               arst_n,
	input  modinv_pkg::sts_t   sts,
	output modinv_pkg::op_t    op
);

	localparam int STEP_BITS = 4;

	typedef logic [STEP_BITS-1:0] step_t;

	typedef enum logic [2:0] {
		CND_ALWAYS,
		CND_WAIT_IN,
		CND_WAIT_DIV,
		CND_WAIT_OUT,
		CND_BR_RZERO,
		CND_BR_MSMALL
	} cond_t;

	typedef struct packed {
		modinv_pkg::op_t op;
		cond_t           cond;
		step_t           target;
	} cw_t;

	localparam step_t ST_IDLE   = 4'd0;
	localparam step_t ST_TEST   = 4'd1;
	localparam step_t ST_DSTART = 4'd2;
	localparam step_t ST_DWAIT  = 4'd3;
	localparam step_t ST_UPDATE = 4'd4;
	localparam step_t ST_CHK    = 4'd5;
	localparam step_t ST_RSTART = 4'd6;
	localparam step_t ST_RWAIT  = 4'd7;
	localparam step_t ST_FIX    = 4'd8;
	localparam step_t ST_BAD    = 4'd9;
	localparam step_t ST_EMIT   = 4'd10;

	function automatic cw_t ucode_rom(step_t a);
		cw_t w;
		case (a)
			ST_IDLE:   w = '{modinv_pkg::OP_LOAD,    CND_WAIT_IN,   ST_TEST};
			ST_TEST:   w = '{modinv_pkg::OP_NOP,     CND_BR_RZERO,  ST_CHK};
			ST_DSTART: w = '{modinv_pkg::OP_DIV_EUC, CND_ALWAYS,    ST_DWAIT};
			ST_DWAIT:  w = '{modinv_pkg::OP_NOP,     CND_WAIT_DIV,  ST_UPDATE};
			ST_UPDATE: w = '{modinv_pkg::OP_UPDATE,  CND_ALWAYS,    ST_TEST};
			ST_CHK:    w = '{modinv_pkg::OP_NOP,     CND_BR_MSMALL, ST_BAD};
			ST_RSTART: w = '{modinv_pkg::OP_DIV_RED, CND_ALWAYS,    ST_RWAIT};
			ST_RWAIT:  w = '{modinv_pkg::OP_NOP,     CND_WAIT_DIV,  ST_FIX};
			ST_FIX:    w = '{modinv_pkg::OP_FIX,     CND_ALWAYS,    ST_EMIT};
			ST_BAD:    w = '{modinv_pkg::OP_BADMOD,  CND_ALWAYS,    ST_EMIT};
			ST_EMIT:   w = '{modinv_pkg::OP_EMIT,    CND_WAIT_OUT,  ST_IDLE};
			default:   w = '{modinv_pkg::OP_NOP,     CND_ALWAYS,    ST_IDLE};
		endcase
		return w;
	endfunction

	step_t step_q;
	step_t step_nx;
	step_t step_inc;
	cw_t   cw;

	assign cw       = ucode_rom(step_q);
	assign step_inc = step_q + 1'b1;

	always_comb begin
		case (cw.cond)
			CND_ALWAYS:    step_nx = cw.target;
			CND_WAIT_IN:   step_nx = sts.in_valid ? cw.target : step_q;
			CND_WAIT_DIV:  step_nx = sts.div_busy ? step_q : cw.target;
			CND_WAIT_OUT:  step_nx = sts.out_free ? cw.target : step_q;
			CND_BR_RZERO:  step_nx = sts.r_zero ? cw.target : step_inc;
			CND_BR_MSMALL: step_nx = sts.m_small ? cw.target : step_inc;
			default:       step_nx = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_IDLE;
		end else begin
			step_q <= step_nx;
		end
	end

	assign op = cw.op;

endmodule

FILE: hdl/modular_inverse_ext_euclid.sv
// channel  signals                                         direction
// in       in_valid, in_stall, value                       beat in, one per item
// out      out_valid, out_stall, inverse, common_divisor,  beat out, one per item
//          no_inverse
// cfg      cfg_wen, cfg_wdata                              modulus write, no wait
//
// one item at a time; each euclid step runs a division on the shared
// bit-serial divider; a final test, check and reduction follow, plus emit
// and load steps
// reset loads modulus 1000000007 and clears control; no clearing pass
// an output beat waits in the output register while out_stall is high
// depends on modinv_pkg, modinv_seq, modinv_div
`timescale 1ns / 1ps

module modular_inverse_ext_euclid #(
	parameter int WORD_BITS = 31
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wen,
	input  logic [WORD_BITS-1:0] cfg_wdata,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [WORD_BITS-1:0] value,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [WORD_BITS-1:0] inverse,
	output logic [WORD_BITS-1:0] common_divisor,
	output logic                 no_inverse
);

	localparam int DW = WORD_BITS + 1;
	localparam int SW = WORD_BITS + 3;

	modinv_pkg::op_t  op;
	modinv_pkg::sts_t sts;

	logic [WORD_BITS-1:0] modulus_q;
	logic [WORD_BITS-1:0] prev_r_q;
	logic [WORD_BITS-1:0] cur_r_q;
	logic signed [SW-1:0] prev_s_q;
	logic signed [SW-1:0] cur_s_q;
	logic [WORD_BITS-1:0] res_inv_q;
	logic                 res_bad_q;
	logic                 out_valid_q;
	logic [WORD_BITS-1:0] inverse_q;
	logic [WORD_BITS-1:0] gcd_q;
	logic                 no_inv_q;

	logic                 accept;
	logic                 out_free;
	logic                 div_start;
	logic [DW-1:0]        div_dividend;
	logic [WORD_BITS-1:0] div_divisor;
	logic signed [SW-1:0] div_mcand;
	logic                 div_busy;
	logic [WORD_BITS-1:0] div_rem;
	logic signed [SW-1:0] div_prod;
	logic [SW-1:0]        s_mag;
	logic                 s_neg;

	assign in_stall = (op != modinv_pkg::OP_LOAD);
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	assign sts.in_valid = in_valid;
	assign sts.div_busy = div_busy;
	assign sts.out_free = out_free;
	assign sts.r_zero   = (cur_r_q == '0);
	assign sts.m_small  = (modulus_q < WORD_BITS'(2));

	modinv_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.op     (op)
	);

	assign s_neg = prev_s_q[SW-1];
	assign s_mag = s_neg ? SW'(-prev_s_q) : SW'(prev_s_q);

	always_comb begin
		div_start    = 1'b0;
		div_dividend = {1'b0, prev_r_q};
		div_divisor  = cur_r_q;
		div_mcand    = cur_s_q;
		case (op)
			modinv_pkg::OP_DIV_EUC: begin
				div_start = 1'b1;
			end
			modinv_pkg::OP_DIV_RED: begin
				div_start    = 1'b1;
				div_dividend = s_mag[DW-1:0];
				div_divisor  = modulus_q;
				div_mcand    = '0;
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	modinv_div #(
		.WORD_BITS (WORD_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.mcand    (div_mcand),
		.busy     (div_busy),
		.rem      (div_rem),
		.prod     (div_prod)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= modinv_pkg::MODULUS_RESET[WORD_BITS-1:0];
		end else if (cfg_wen) begin
			modulus_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		case (op)
			modinv_pkg::OP_LOAD: begin
				if (accept) begin
					prev_r_q <= value;
					cur_r_q  <= modulus_q;
					prev_s_q <= SW'(1);
					cur_s_q  <= '0;
				end
			end
			modinv_pkg::OP_UPDATE: begin
				prev_r_q <= cur_r_q;
				cur_r_q  <= div_rem;
				prev_s_q <= cur_s_q;
				cur_s_q  <= prev_s_q - div_prod;
			end
			modinv_pkg::OP_FIX: begin
				res_inv_q <= (s_neg && div_rem != '0) ? (modulus_q - div_rem) : div_rem;
				res_bad_q <= (prev_r_q != WORD_BITS'(1));
			end
			modinv_pkg::OP_BADMOD: begin
				res_inv_q <= '0;
				res_bad_q <= 1'b1;
			end
			default: begin
				res_bad_q <= res_bad_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (op == modinv_pkg::OP_EMIT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (op == modinv_pkg::OP_EMIT && out_free) begin
			inverse_q <= res_inv_q;
			gcd_q     <= prev_r_q;
			no_inv_q  <= res_bad_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign inverse        = inverse_q;
	assign common_divisor = gcd_q;
	assign no_inverse     = no_inv_q;

endmodule

FILE: hdl/modinv_chk.sv
// modinv_chk: port-level checks for the modular inverse block
// bound to modular_inverse_ext_euclid; depends on its port list only
`timescale 1ns / 1ps

module modinv_chk #(
	parameter int WORD_BITS = 31
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_stall,
	input logic                 out_valid,
	input logic                 out_stall,
	input logic [WORD_BITS-1:0] inverse,
	input logic [WORD_BITS-1:0] common_divisor,
	input logic                 no_inverse
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(inverse)
			&& $stable(common_divisor) && $stable(no_inverse))
		else $error("stalled output beat changed");

	a_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while previous item still running");

	a_gcd_one: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !no_inverse |-> common_divisor == WORD_BITS'(1))
		else $error("valid inverse with gcd not one");

	a_inv_nz: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !no_inverse |-> inverse != '0)
		else $error("valid inverse is zero");

endmodule

bind modular_inverse_ext_euclid modinv_chk #(.WORD_BITS(WORD_BITS)) u_modinv_chk (.*);
